[sv/twd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile wall dilation package
// Shared types, tile codes, register map and sizes for the 3x3 wall
// dilation block and its submodules.
// ----------------------------------------------------------------------------
package twd_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  // Configuration register width and APB port sizes.
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Column position, live width, row position (rows run up to height + 1).
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(80);
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(24);

  // Window cells in the chain; the third window column is the incoming one.
  localparam int unsigned NCELLS = 2;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [1:0] tile_t;

  localparam tile_t CODE_EMPTY = 2'd0;
  localparam tile_t CODE_FLOOR = 2'd1;
  localparam tile_t CODE_WALL  = 2'd2;

  // One window column, index 0 is the top row.
  typedef tile_t [2:0] col_t;

  typedef struct packed {
    logic  cmd;
    tile_t tile_code;
  } in_beat_t;

  typedef struct packed {
    tile_t out_tile;
    logic  last_of_frame;
  } out_beat_t;

  // One line buffer entry: tiles two rows back and one row back.
  typedef struct packed {
    tile_t above;
    tile_t current;
  } lb_entry_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    lb_entry_t        data;
  } lb_wr_t;

  function automatic logic [2:0] floor_flags(input col_t c);
    logic [2:0] f;
    for (int r = 0; r < 3; r++) begin
      f[r] = (c[r] == CODE_FLOOR);
    end
    return f;
  endfunction

endpackage

[sv/twd_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile wall dilation line buffer
// One entry per column holding the two previous rows, with a registered
// read port and write-to-read bypass for the same address.
// ----------------------------------------------------------------------------
module twd_line_buf (
  input  logic                            clk_i,
  input  twd_pkg::lb_wr_t                 wr_i,
  input  logic [twd_pkg::COL_W-1:0]       raddr_i,
  output twd_pkg::lb_entry_t              rdata_o
);

  twd_pkg::lb_entry_t mem_q [twd_pkg::MAX_WIDTH];
  twd_pkg::lb_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // A one-column grid reads the entry it writes in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == raddr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

[sv/twd_col_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile wall dilation window cell
// Holds one three-tile column of the window and passes it to its left
// neighbor on every beat that advances the frame position.
// ----------------------------------------------------------------------------
module twd_col_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  twd_pkg::col_t col_i,
  output twd_pkg::col_t col_o,
  output logic [2:0]    floor_o
);

  twd_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o   = col_q;
  assign floor_o = twd_pkg::floor_flags(col_q);

endmodule

[sv/tile_wall_dilation_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile wall dilation 3x3
// Turns empty tiles next to a floor tile into walls over a raster tile grid.
// ----------------------------------------------------------------------------
// Usage: tiles enter in raster order on the input channel, one beat per tile
// (cmd = 0). After the last tile of the grid, drain beats (cmd = 1) flush the
// results still pending; a drain sent before the grid is complete is taken
// and dropped. Grid width and height are set over the APB port while idle;
// any write restarts the frame. Each result beat carries the tile and a flag
// on the final tile of the grid.
// Throughput: one beat per cycle on both channels when not stalled. Two
// window cells shift on every beat that moves the frame, and the line buffer
// is read one beat ahead; its single registered read port keeps up with it.
// Result path: the result for a tile is formed when the tile one row plus one
// column later is taken, and is then registered into the output register.
// Stall: the output register is backed by a one-beat skid register, so input
// keeps flowing while a result waits; in_stall_o rises only when both hold.
// Reset: 80 x 24 grid, frame position at the start, window cleared, output
// empty. The line buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module tile_wall_dilation_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  twd_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output twd_pkg::out_beat_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twd_pkg::PADDR_W-1:0]   paddr,
  input  logic [twd_pkg::PDATA_W-1:0]   pwdata,
  output logic [twd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [twd_pkg::CFG_W-1:0] grid_width_q, grid_height_q;
  logic [twd_pkg::DIM_W-1:0] w_live;
  logic [twd_pkg::ROW_W-1:0] h_live;
  logic                      cfg_wr;
  twd_pkg::reg_idx_e         reg_idx;

  logic [twd_pkg::COL_W-1:0] col_q, col_d;
  logic [twd_pkg::ROW_W-1:0] row_q, row_d;

  logic               in_acc, in_frame, step, col_first, emit, last, col_wrap;
  twd_pkg::tile_t     incoming, center, res;
  twd_pkg::lb_entry_t lb_rd;
  twd_pkg::lb_wr_t    lb_wr;
  twd_pkg::col_t      new_col;
  twd_pkg::col_t      win      [twd_pkg::NCELLS];
  twd_pkg::col_t      chain_in [twd_pkg::NCELLS];
  logic [2:0]         win_floor [twd_pkg::NCELLS];
  logic [2:0]         new_floor, row_ok;
  logic               top_ok, bot_ok, left_ok, right_ok, near;

  logic               r_valid;
  twd_pkg::out_beat_t r_beat;
  logic               out_valid_q, skid_valid_q, pop;
  twd_pkg::out_beat_t out_q, skid_q;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = twd_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= twd_pkg::GRID_WIDTH_RST;
      grid_height_q <= twd_pkg::GRID_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        twd_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[twd_pkg::CFG_W-1:0];
        twd_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[twd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      twd_pkg::REG_GRID_WIDTH:  prdata = twd_pkg::PDATA_W'(grid_width_q);
      twd_pkg::REG_GRID_HEIGHT: prdata = twd_pkg::PDATA_W'(grid_height_q);
      default:                  prdata = '0;
    endcase
  end

  // Out-of-range sizes act as the nearest legal size.
  always_comb begin
    if (grid_width_q == '0) begin
      w_live = twd_pkg::DIM_W'(1);
    end else if (32'(grid_width_q) > twd_pkg::MAX_WIDTH) begin
      w_live = twd_pkg::DIM_W'(twd_pkg::MAX_WIDTH);
    end else begin
      w_live = twd_pkg::DIM_W'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      h_live = twd_pkg::ROW_W'(1);
    end else if (32'(grid_height_q) > twd_pkg::MAX_HEIGHT) begin
      h_live = twd_pkg::ROW_W'(twd_pkg::MAX_HEIGHT);
    end else begin
      h_live = twd_pkg::ROW_W'(grid_height_q);
    end
  end

  // ---------------- position tracking ----------------
  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_frame  = row_q < h_live;
  assign step      = in_acc && !(in_frame && in_data_i.cmd);
  assign incoming  = in_frame ? in_data_i.tile_code : twd_pkg::CODE_EMPTY;
  assign col_first = (col_q == '0);
  assign emit      = col_first ? (row_q >= twd_pkg::ROW_W'(2))
                               : (row_q >= twd_pkg::ROW_W'(1));
  // The final tile leaves at the first column of the second row past the grid.
  assign last      = col_first &&
                     ({1'b0, row_q} == ({1'b0, h_live} + (twd_pkg::ROW_W+1)'(1)));
  assign col_wrap  = ({1'b0, col_q} + (twd_pkg::COL_W+1)'(1)) >= w_live;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (step) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + twd_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + twd_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- line buffer ----------------
  // The read address follows the next position, so the entry for the
  // current position is already registered when its beat arrives.
  assign lb_wr.en           = step;
  assign lb_wr.addr         = col_q;
  assign lb_wr.data.above   = lb_rd.current;
  assign lb_wr.data.current = incoming;

  twd_line_buf u_line_buf (
    .clk_i   (clk_i),
    .wr_i    (lb_wr),
    .raddr_i (col_d),
    .rdata_o (lb_rd)
  );

  // ---------------- window cells ----------------
  assign new_col[0] = lb_rd.above;
  assign new_col[1] = lb_rd.current;
  assign new_col[2] = incoming;

  for (genvar k = 0; k < twd_pkg::NCELLS; k++) begin : g_cell
    if (k == twd_pkg::NCELLS - 1) begin : g_edge
      assign chain_in[k] = new_col;
    end else begin : g_inner
      assign chain_in[k] = win[k+1];
    end
    twd_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step),
      .col_i   (chain_in[k]),
      .col_o   (win[k]),
      .floor_o (win_floor[k])
    );
  end

  // ---------------- neighborhood test ----------------
  // The tile under test sits in the middle row of the newest stored column.
  // In the first column it is the last tile of an earlier row, so the
  // incoming column does not belong to its neighborhood.
  assign new_floor = twd_pkg::floor_flags(new_col);
  assign center    = win[1][1];
  assign top_ok    = col_first ? (row_q != twd_pkg::ROW_W'(2))
                               : (row_q != twd_pkg::ROW_W'(1));
  assign bot_ok    = col_first ? (row_q <= h_live) : (row_q < h_live);
  assign left_ok   = col_first ? (w_live != twd_pkg::DIM_W'(1))
                               : (col_q != twd_pkg::COL_W'(1));
  assign right_ok  = !col_first;
  assign row_ok    = {bot_ok, 1'b1, top_ok};

  assign near = (|(win_floor[0] & row_ok) && left_ok) ||
                (|(win_floor[1] & row_ok & 3'b101)) ||
                (|(new_floor & row_ok) && right_ok);

  assign res = (center != twd_pkg::CODE_EMPTY) ? center :
               (near ? twd_pkg::CODE_WALL : twd_pkg::CODE_EMPTY);

  assign r_valid              = step && emit;
  assign r_beat.out_tile      = res;
  assign r_beat.last_of_frame = last;

  // ---------------- output register and skid ----------------
  assign pop        = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= r_valid;
      end else begin
        out_valid_q  <= r_valid;
      end
    end else if (r_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= r_beat;
      end else begin
        out_q  <= r_beat;
      end
    end else if (r_valid) begin
      skid_q <= r_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/twd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile wall dilation port checker
// Watches the stream ports of the top level and flags handshake and
// buffering slips.
// ----------------------------------------------------------------------------
module twd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input twd_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input twd_pkg::out_beat_t out_data_o
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A result beat never appears without an input beat taken just before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output beat without a preceding input beat");

  // Input stalls only once a held result has backed up into the skid stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o && out_stall_i))
    else $error("input stalled while the output side was free");

  // A stalled input beat stays offered with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

endmodule

bind tile_wall_dilation_3x3 twd_checker u_twd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
